// ===== sv/cnms_pkg.sv =====
// shared types and constants of the canny non-maximum suppression unit
`default_nettype none

package cnms_pkg;

  localparam int MAG_W   = 15;
  localparam int DER_W   = 16;
  localparam int LEN_W   = 11;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CLASS_W = 2;
  localparam int PROD_W  = DER_W + MAG_W;

  // line store entry: {derivative pair, centre magnitude, previous magnitude}
  localparam int MEM_W = 2 * DER_W + 2 * MAG_W;

  localparam int MAX_LINE_DEF = 1024;

  localparam logic [LEN_W-1:0] LINE_LENGTH_RST = LEN_W'(640);
  localparam logic [CNT_W-1:0] LINE_COUNT_RST  = CNT_W'(480);

  localparam logic CFG_LINE_LENGTH = 1'b0;
  localparam logic CFG_LINE_COUNT  = 1'b1;

  localparam logic [CLASS_W-1:0] EDGE_BORDER   = 2'd0;
  localparam logic [CLASS_W-1:0] EDGE_NONE     = 2'd1;
  localparam logic [CLASS_W-1:0] EDGE_POSSIBLE = 2'd2;

  typedef struct packed {
    logic                    is_padding;
    logic [MAG_W-1:0]        grad_mag;
    logic signed [DER_W-1:0] grad_x;
    logic signed [DER_W-1:0] grad_y;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] edge_class;
    logic               end_of_frame;
  } out_item_t;

  // operands of the interpolated test for one window centre
  typedef struct packed {
    logic [DER_W-1:0] major;
    logic [DER_W-1:0] minor;
    logic [DER_W-1:0] diff;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] g1;
    logic [MAG_W-1:0] g2;
    logic [MAG_W-1:0] g3;
    logic [MAG_W-1:0] g4;
    logic             zero;
    logic             border;
    logic             eof;
  } nms_ops_t;

endpackage

`default_nettype wire

// ===== sv/cnms_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module cnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read during write to the same entry returns the old data
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cnms_classify.sv =====
// product and compare stages of the interpolated suppression test
`default_nettype none

module cnms_classify (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                ops_valid,
  input  wire cnms_pkg::nms_ops_t  ops,
  output logic                     res_valid,
  output cnms_pkg::out_item_t      res
);

  logic [cnms_pkg::PROD_W-1:0] p_mm_r, p_a1_r, p_b1_r, p_a3_r, p_b3_r;
  logic                        s3_valid_r, s3_zero_r, s3_border_r, s3_eof_r;
  logic [cnms_pkg::PROD_W:0]   side1, side3, lhs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= ops_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_mm_r      <= ops.major * ops.mag;
      p_a1_r      <= ops.minor * ops.g1;
      p_b1_r      <= ops.diff * ops.g2;
      p_a3_r      <= ops.minor * ops.g3;
      p_b3_r      <= ops.diff * ops.g4;
      s3_zero_r   <= ops.zero;
      s3_border_r <= ops.border;
      s3_eof_r    <= ops.eof;
    end
  end

  always_comb begin
    lhs   = {1'b0, p_mm_r};
    side1 = {1'b0, p_a1_r} + {1'b0, p_b1_r};
    side3 = {1'b0, p_a3_r} + {1'b0, p_b3_r};
    res.end_of_frame = s3_eof_r;
    if (s3_border_r) begin
      res.edge_class = cnms_pkg::EDGE_BORDER;
    end else if (s3_zero_r) begin
      res.edge_class = cnms_pkg::EDGE_NONE;
    end else if (lhs >= side1 && lhs >= side3) begin
      res.edge_class = cnms_pkg::EDGE_POSSIBLE;
    end else begin
      res.edge_class = cnms_pkg::EDGE_NONE;
    end
  end

  assign res_valid = s3_valid_r;

endmodule

`default_nettype wire

// ===== sv/canny_nonmax_suppression_unit.sv =====
// canny non-maximum suppression: streaming 3x3 window with interpolated test
//
// Gradient items (magnitude, x and y derivative) enter on in_valid/in_ready in
// raster order, one per cycle unless stalled. Each pixel is classified once its
// 3x3 neighbourhood is complete, i.e. one line plus one item after it enters;
// line_length+1 padding items after the last pixel flush the frame tail, and
// the last result carries end_of_frame. Padding inside the pixel region is
// taken and dropped.
// A result leaves on out_valid/out_ready after the stage 1, stage 2, product
// and output registers. The line stores sit in one ram addressed by column
// (read when an item is taken, written back from stage 1); throughput is one
// item per cycle while no stall holds the pipeline.
// An output register plus one skid entry part the two sides: while out_ready
// is low one more result is absorbed, then in_ready drops and the whole
// pipeline holds.
// Reset (synchronous, rst_n low) loads line_length 640 and line_count 480 and
// restarts the frame at pixel (0,0); the line store needs no clearing pass as
// its unwritten entries only reach border pixels. A cfg write restarts the
// frame too; the user must make it only while the block is idle (not enforced).
`default_nettype none

module canny_nonmax_suppression_unit #(
  parameter int MAX_LINE = cnms_pkg::MAX_LINE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire cnms_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output cnms_pkg::out_item_t             out_data,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [cnms_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int CW    = $clog2(MAX_LINE);
  localparam int LW    = CW + 1;
  localparam int ROW_W = cnms_pkg::CNT_W + 1;
  localparam int MAG_W = cnms_pkg::MAG_W;
  localparam int DER_W = cnms_pkg::DER_W;

  // configuration and position
  logic [cnms_pkg::LEN_W-1:0] line_length_r;
  logic [cnms_pkg::CNT_W-1:0] line_count_r;
  logic [CW-1:0]              col_r, col_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [LW-1:0]              len_eff, col_ext, col_inc, c_pos;
  logic [CW-1:0]              col_cur;
  logic [ROW_W-1:0]           cnt_ext, r_pos;
  logic                       flush, ignore, step, emit, border, eof;
  logic                       en, accept;

  // stage 1: ram read data arrives
  logic                       s1_v_r, s1_emit_r, s1_border_r, s1_eof_r;
  logic [MAG_W-1:0]           s1_mag_r;
  logic [2*DER_W-1:0]         s1_deriv_r;
  logic [CW-1:0]              s1_col_r;
  logic [cnms_pkg::MEM_W-1:0] rd_data, wr_data;
  logic [MAG_W-1:0]           rd_top, rd_mid;
  logic [2*DER_W-1:0]         rd_deriv;
  logic [MAG_W-1:0]           window_r [9];
  logic [MAG_W-1:0]           window_nxt [9];
  logic [2*DER_W-1:0]         deriv_hold_r;
  logic signed [DER_W-1:0]    gx, gy;
  logic [DER_W-1:0]           ax, ay;
  logic                       same;
  logic                       s1_adv;

  // stage 2: test operands
  logic                       s2_v_r;
  cnms_pkg::nms_ops_t         ops_r, ops_nxt;

  // result and output
  logic                       res_valid, p_v;
  cnms_pkg::out_item_t        res;
  logic                       out_valid_r, skid_valid_r;
  cnms_pkg::out_item_t        out_data_r, skid_data_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign accept   = in_valid && en;

  // ---------------------------------------------------------------- position
  always_comb begin
    if (line_length_r < cnms_pkg::LEN_W'(3)) begin
      len_eff = LW'(3);
    end else if (int'(line_length_r) > MAX_LINE) begin
      len_eff = LW'(MAX_LINE);
    end else begin
      len_eff = LW'(line_length_r);
    end
    if (line_count_r < cnms_pkg::CNT_W'(3)) begin
      cnt_ext = ROW_W'(3);
    end else begin
      cnt_ext = {1'b0, line_count_r};
    end

    col_cur = ({1'b0, col_r} >= len_eff) ? '0 : col_r;
    col_ext = {1'b0, col_cur};
    col_inc = col_ext + LW'(1);

    flush  = row_r >= cnt_ext;
    ignore = in_data.is_padding && !flush;
    step   = accept && !ignore;

    emit   = (row_r >= ROW_W'(2)) || (row_r == ROW_W'(1) && col_cur != '0);
    r_pos  = (col_cur != '0) ? row_r - ROW_W'(1) : row_r - ROW_W'(2);
    c_pos  = (col_cur != '0) ? col_ext - LW'(1) : len_eff - LW'(1);
    border = (r_pos == '0) || (r_pos >= cnt_ext - ROW_W'(1)) ||
             (c_pos == '0) || (c_pos >= len_eff - LW'(1));
    eof    = (row_r == cnt_ext + ROW_W'(1)) && (col_cur == '0);

    if (eof) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= len_eff) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= cnms_pkg::LINE_LENGTH_RST;
      line_count_r  <= cnms_pkg::LINE_COUNT_RST;
      col_r         <= '0;
      row_r         <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cnms_pkg::CFG_LINE_LENGTH: line_length_r <= cfg_wdata[cnms_pkg::LEN_W-1:0];
        cnms_pkg::CFG_LINE_COUNT:  line_count_r  <= cfg_wdata[cnms_pkg::CNT_W-1:0];
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ------------------------------------------------------------- line store
  assign s1_adv  = s1_v_r && en;
  assign wr_data = {s1_deriv_r, s1_mag_r, rd_mid};

  cnms_ram #(
    .WIDTH(cnms_pkg::MEM_W),
    .DEPTH(MAX_LINE)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (s1_adv),
    .wr_addr(s1_col_r),
    .wr_data(wr_data),
    .rd_en  (step),
    .rd_addr(col_cur),
    .rd_data(rd_data)
  );

  assign rd_top   = rd_data[MAG_W-1:0];
  assign rd_mid   = rd_data[2*MAG_W-1:MAG_W];
  assign rd_deriv = rd_data[cnms_pkg::MEM_W-1:2*MAG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= step;
    end
  end

  // flush items enter the stores as zero
  always_ff @(posedge clk) begin
    if (step) begin
      s1_mag_r    <= flush ? '0 : in_data.grad_mag;
      s1_deriv_r  <= flush ? '0 : {in_data.grad_y, in_data.grad_x};
      s1_col_r    <= col_cur;
      s1_emit_r   <= emit;
      s1_border_r <= border;
      s1_eof_r    <= eof;
    end
  end

  // ------------------------------------------------- window and test operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      window_nxt[i*3]     = window_r[i*3+1];
      window_nxt[i*3 + 1] = window_r[i*3+2];
    end
    window_nxt[2] = rd_top;
    window_nxt[5] = rd_mid;
    window_nxt[8] = s1_mag_r;

    gx   = deriv_hold_r[DER_W-1:0];
    gy   = deriv_hold_r[2*DER_W-1:DER_W];
    ax   = gx[DER_W-1] ? DER_W'(~gx + DER_W'(1)) : gx;
    ay   = gy[DER_W-1] ? DER_W'(~gy + DER_W'(1)) : gy;
    same = (!gx[DER_W-1] && gx != '0 && !gy[DER_W-1] && gy != '0) ||
           (gx[DER_W-1] && gy[DER_W-1]);

    ops_nxt.mag    = window_nxt[4];
    ops_nxt.zero   = (window_nxt[4] == '0);
    ops_nxt.border = s1_border_r;
    ops_nxt.eof    = s1_eof_r;
    if (ay > ax) begin
      ops_nxt.major = ay;
      ops_nxt.minor = ax;
      ops_nxt.g2    = window_nxt[1];
      ops_nxt.g4    = window_nxt[7];
      ops_nxt.g1    = same ? window_nxt[0] : window_nxt[2];
      ops_nxt.g3    = same ? window_nxt[8] : window_nxt[6];
    end else begin
      ops_nxt.major = ax;
      ops_nxt.minor = ay;
      ops_nxt.g2    = window_nxt[5];
      ops_nxt.g4    = window_nxt[3];
      ops_nxt.g1    = same ? window_nxt[8] : window_nxt[2];
      ops_nxt.g3    = same ? window_nxt[0] : window_nxt[6];
    end
    ops_nxt.diff = ops_nxt.major - ops_nxt.minor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        window_r[i] <= '0;
      end
      deriv_hold_r <= '0;
      s2_v_r       <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r && s1_emit_r;
      if (s1_v_r) begin
        window_r     <= window_nxt;
        deriv_hold_r <= rd_deriv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ops_r <= ops_nxt;
    end
  end

  cnms_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ops_valid(s2_v_r),
    .ops      (ops_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // ------------------------------------------------------ output and skid
  assign p_v = res_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= p_v;
      out_data_r  <= res;
    end else if (p_v) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------- assertions
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_eof_is_border : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_frame) |->
      (out_data.edge_class == cnms_pkg::EDGE_BORDER))
    else $error("frame's final pixel not classed as border");

  a_col_in_line : assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < len_eff))
    else $error("column counter beyond line length");

  a_row_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= cnt_ext + ROW_W'(1)))
    else $error("row counter beyond flush region");

  a_stall_holds_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    (!en && s2_v_r) |=> s2_v_r)
    else $error("pipeline stage lost an item while stalled");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for canny_nonmax_suppression_unit: random frames checked against a window model
`timescale 1ns / 1ps

module tb_top;
  import cnms_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned RANDOM_PIXELS  = 200;
  localparam int unsigned QUIET_AFTER    = 150;

  typedef struct {
    out_item_t   res;
    int unsigned row;
    int unsigned col;
  } class_due_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = CFG_LINE_LENGTH;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  canny_nonmax_suppression_unit #(
    .MAX_LINE(MAX_LINE_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // pixel stream waiting for the driver, and classes still to come out
  in_item_t    pixel_q[$];
  class_due_t  edge_class_q[$];

  int unsigned items_pushed   = 0;
  int unsigned items_taken    = 0;
  int unsigned pixels_sent    = 0;
  int unsigned results_seen   = 0;
  int unsigned frames_done    = 0;
  int unsigned cfg_writes     = 0;
  int unsigned error_count    = 0;
  int unsigned stalled_cycles = 0;
  int unsigned frame_len      = 3;
  int unsigned frame_cnt      = 3;
  logic        in_fire        = 1'b0;
  logic        gaps_on        = 1'b1;
  int unsigned in_gap         = 0;
  int unsigned rdy_gap        = 0;

  // window model state
  logic [LEN_W-1:0]  len_reg;
  logic [CNT_W-1:0]  cnt_reg;
  logic [MAG_W-1:0]  line_prev_mag[MAX_LINE_DEF];
  logic [MAG_W-1:0]  line_ctr_mag[MAX_LINE_DEF];
  logic [31:0]       line_ctr_deriv[MAX_LINE_DEF];
  logic [31:0]       centre_deriv;
  logic [MAG_W-1:0]  win_mag[9];
  int unsigned       pos_col;
  int unsigned       pos_row;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned eff_len(input logic [LEN_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_LINE_DEF) return MAX_LINE_DEF;
    return v;
  endfunction

  function automatic int unsigned eff_cnt(input logic [CNT_W-1:0] v);
    return (v < 3) ? 3 : v;
  endfunction

  // interpolated test on the window centre, exact integer form
  function automatic logic [CLASS_W-1:0] interp_class();
    logic signed [DER_W-1:0] gx, gy;
    longint ax, ay, major, minor, m, g1, g2, g3, g4;
    logic same;
    gx = centre_deriv[DER_W-1:0];
    gy = centre_deriv[2*DER_W-1:DER_W];
    ax = (gx < 0) ? -longint'(gx) : longint'(gx);
    ay = (gy < 0) ? -longint'(gy) : longint'(gy);
    same = (gx > 0 && gy > 0) || (gx < 0 && gy < 0);
    m = win_mag[4];
    if (m == 0) return EDGE_NONE;
    if (ay > ax) begin
      major = ay; minor = ax;
      g2 = win_mag[1]; g4 = win_mag[7];
      if (same) begin
        g1 = win_mag[0]; g3 = win_mag[8];
      end else begin
        g1 = win_mag[2]; g3 = win_mag[6];
      end
    end else begin
      major = ax; minor = ay;
      g2 = win_mag[5]; g4 = win_mag[3];
      if (same) begin
        g1 = win_mag[8]; g3 = win_mag[0];
      end else begin
        g1 = win_mag[2]; g3 = win_mag[6];
      end
    end
    if (major * m >= minor * g1 + (major - minor) * g2 &&
        major * m >= minor * g3 + (major - minor) * g4)
      return EDGE_POSSIBLE;
    return EDGE_NONE;
  endfunction

  // shift one item into the window and queue the class it completes
  task automatic advance_window(input in_item_t it);
    int unsigned len, cnt, colx, r, c, k;
    logic flush, emit, eof;
    logic [MAG_W-1:0] mag, top, mid;
    logic [31:0] d;
    class_due_t due;
    len  = eff_len(len_reg);
    cnt  = eff_cnt(cnt_reg);
    colx = (pos_col >= len) ? 0 : pos_col;
    flush = pos_row >= cnt;
    if (it.is_padding && !flush) return;  // padding inside the frame is dropped
    mag = flush ? '0 : it.grad_mag;
    d   = flush ? '0 : {it.grad_y, it.grad_x};
    top = line_prev_mag[colx];
    mid = line_ctr_mag[colx];
    for (k = 0; k < 3; k++) begin
      win_mag[k*3]   = win_mag[k*3+1];
      win_mag[k*3+1] = win_mag[k*3+2];
    end
    win_mag[2] = top;
    win_mag[5] = mid;
    win_mag[8] = mag;
    line_prev_mag[colx] = mid;
    line_ctr_mag[colx]  = mag;
    emit = pos_row >= 2 || (pos_row == 1 && colx >= 1);
    due.res.edge_class = EDGE_BORDER;
    due.row = 0;
    due.col = 0;
    if (emit) begin
      r = (colx >= 1) ? pos_row - 1 : pos_row - 2;
      c = (colx >= 1) ? colx - 1 : len - 1;
      due.row = r;
      due.col = c;
      if (!(r == 0 || r >= cnt - 1 || c == 0 || c >= len - 1))
        due.res.edge_class = interp_class();
    end
    centre_deriv = line_ctr_deriv[colx];
    line_ctr_deriv[colx] = d;
    eof = pos_row == cnt + 1 && colx == 0;
    if (eof) begin
      pos_row = 0;
      colx = 0;
    end else begin
      colx++;
      if (colx >= len) begin
        colx = 0;
        pos_row++;
      end
    end
    pos_col = colx;
    if (emit) begin
      due.res.end_of_frame = eof;
      edge_class_q.push_back(due);
    end
  endtask

  // result check and model update, all on the rising edge
  always @(posedge clk) begin : result_monitor
    class_due_t want;
    in_fire <= in_valid && in_ready;
    if (!rst_n) begin
      len_reg = LINE_LENGTH_RST;
      cnt_reg = LINE_COUNT_RST;
      for (int k = 0; k < MAX_LINE_DEF; k++) begin
        line_prev_mag[k]  = '0;
        line_ctr_mag[k]   = '0;
        line_ctr_deriv[k] = '0;
      end
      for (int k = 0; k < 9; k++) win_mag[k] = '0;
      centre_deriv = '0;
      pos_col = 0;
      pos_row = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (edge_class_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: class %0d eof %0b",
                                    out_data.edge_class, out_data.end_of_frame));
        end else begin
          want = edge_class_q.pop_front();
          if (out_data.edge_class !== want.res.edge_class)
            report_mismatch($sformatf("pixel (%0d,%0d) edge_class %0d, expected %0d",
                                      want.row, want.col, out_data.edge_class,
                                      want.res.edge_class));
          if (out_data.end_of_frame !== want.res.end_of_frame)
            report_mismatch($sformatf("pixel (%0d,%0d) end_of_frame %0b, expected %0b",
                                      want.row, want.col, out_data.end_of_frame,
                                      want.res.end_of_frame));
          if (want.res.end_of_frame) frames_done++;
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_LINE_LENGTH)
          len_reg = cfg_wdata[LEN_W-1:0];
        else
          cnt_reg = cfg_wdata[CNT_W-1:0];
        pos_col = 0;
        pos_row = 0;
      end
      if (in_valid && in_ready) begin
        items_taken++;
        advance_window(in_data);
      end
    end
  end

  // driver: items and ready change on the falling edge, with random gaps while gaps_on is set
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pixel_q.pop_front();
        if (gaps_on && $urandom_range(0, 9) == 0)
          in_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (rdy_gap > 0) begin
      rdy_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
      if (gaps_on && $urandom_range(0, 11) == 0)
        rdy_gap = $urandom_range(1, 18);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      stalled_cycles = 0;
    else
      stalled_cycles++;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d items left to send, %0d results pending",
               STALL_LIMIT, items_pushed - items_taken, edge_class_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_item(input in_item_t it);
    pixel_q.push_back(it);
    items_pushed++;
  endtask

  function automatic in_item_t make_pixel(input int m, input int x, input int y);
    in_item_t it;
    it.is_padding = 1'b0;
    it.grad_mag   = MAG_W'(m);
    it.grad_x     = DER_W'(x);
    it.grad_y     = DER_W'(y);
    return it;
  endfunction

  function automatic in_item_t random_fill(input logic pad);
    in_item_t it;
    it.is_padding = pad;
    it.grad_mag   = MAG_W'($urandom);
    it.grad_x     = DER_W'($urandom);
    it.grad_y     = DER_W'($urandom);
    return it;
  endfunction

  function automatic logic signed [DER_W-1:0] rand_deriv();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: v = -32768;
      2: v = 32767;
      3: v = 0;
      default: v = int'($urandom_range(0, 20)) - 10;
    endcase
    return DER_W'(v);
  endfunction

  function automatic in_item_t rand_pixel();
    in_item_t it;
    it.is_padding = 1'b0;
    case ($urandom_range(0, 9))
      0: it.grad_mag = '0;
      1: it.grad_mag = MAG_W'($urandom);
      2: it.grad_mag = '1;
      default: it.grad_mag = MAG_W'($urandom_range(0, 40));
    endcase
    it.grad_x = rand_deriv();
    // equal axis magnitudes now and then, to hit the tie towards x
    if ($urandom_range(0, 5) == 0)
      it.grad_y = $urandom_range(0, 1) ? it.grad_x : -it.grad_x;
    else
      it.grad_y = rand_deriv();
    return it;
  endfunction

  // cut = 0 sends the whole frame and its flush, otherwise only cut pixels
  task automatic push_frame(input int unsigned cut);
    int unsigned n, k;
    n = (cut != 0) ? cut : frame_len * frame_cnt;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) push_item(random_fill(1'b1));
      push_item(rand_pixel());
    end
    if (cut == 0)
      for (k = 0; k <= frame_len; k++)
        push_item(random_fill($urandom_range(0, 4) != 0));
    pixels_sent += n;
  endtask

  task automatic wait_idle();
    while (items_taken != items_pushed || edge_class_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] len_raw, input logic [CFG_W-1:0] cnt_raw);
    wait_idle();
    write_reg(CFG_LINE_LENGTH, len_raw);
    write_reg(CFG_LINE_COUNT, cnt_raw);
    frame_len = eff_len(len_raw[LEN_W-1:0]);
    frame_cnt = eff_cnt(cnt_raw[CNT_W-1:0]);
  endtask

  // 5x3 frame: field extremes on the border, zero magnitude and zero
  // derivatives in the centre row, padding inside the frame and pixel
  // items in the flush tail
  task automatic push_directed_frame();
    int dmag[15] = '{100, 200, 32767, 0, 50,
                     7, 900, 0, 500, 32767,
                     300, 10, 400, 20, 1};
    int dgx[15]  = '{-32768, 32767, 0, 1, -1,
                     5, 0, -32768, 32767, 3,
                     0, -4, 9, 100, -32768};
    int dgy[15]  = '{32767, -32768, 2, -2, 0,
                     -5, 0, 32767, -32768, 7,
                     0, 4, -9, 100, 32767};
    int k;
    for (k = 0; k < 15; k++) begin
      push_item(make_pixel(dmag[k], dgx[k], dgy[k]));
      if (k == 3 || k == 8) push_item(random_fill(1'b1));
    end
    for (k = 0; k <= 5; k++)
      push_item(random_fill(!(k == 2 || k == 4)));
    pixels_sent += 15;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] lraw, craw;
    int unsigned reps, f, base, total;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    set_frame(CFG_W'(5), CFG_W'(3));
    push_directed_frame();

    // all-ones on both registers: lines clamp to the longest, frame cut short
    set_frame('1, '1);
    push_frame(60);
    set_frame(CFG_W'(3), CFG_W'(3));
    push_frame(0);
    push_frame(0);

    base = pixels_sent;
    while (pixels_sent - base < RANDOM_PIXELS) begin
      if (pixels_sent - base > QUIET_AFTER) gaps_on = 1'b0;
      case ($urandom_range(0, 7))
        0: lraw = CFG_W'($urandom_range(0, 2));
        1: lraw = CFG_W'(3);
        default: lraw = CFG_W'($urandom_range(3, 10));
      endcase
      // upper bits above the line length field are junk
      lraw[CFG_W-1:LEN_W] = (CFG_W - LEN_W)'($urandom);
      case ($urandom_range(0, 7))
        0: craw = CFG_W'($urandom_range(0, 2));
        1: craw = CFG_W'(3);
        default: craw = CFG_W'($urandom_range(3, 7));
      endcase
      set_frame(lraw, craw);
      reps = $urandom_range(1, 3);
      for (f = 0; f < reps; f++) begin
        total = frame_len * frame_cnt;
        if ($urandom_range(0, 5) == 0) begin
          push_frame($urandom_range(1, total - 1));
          break;
        end
        push_frame(0);
      end
    end

    wait_idle();
    if (edge_class_q.size() != 0)
      report_mismatch($sformatf("%0d results never came out", edge_class_q.size()));
    $display("sent %0d items (%0d pixels) over %0d register writes, lines of 3 to 1024",
             items_pushed, pixels_sent, cfg_writes);
    $display("checked %0d results in %0d complete frames, %0d mismatches",
             results_seen, frames_done, error_count);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
